/* hw/rtl/rhps_pkg.sv */
// Shared types, constants and the byte-to-digit function for the rolling hash search.
`timescale 1ns / 1ps
`default_nettype none

package rhps_pkg;

    // Default sizes
    localparam int MAX_PATTERN_LENGTH_DEF = 16;
    localparam int POSITION_BITS_DEF      = 24;

    // Fixed field widths
    localparam int HASH_W    = 27;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int PLEN_W    = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

    // Result kinds
    localparam logic KIND_HASH     = 1'b0;
    localparam logic KIND_POSITION = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;     // take the input request, shift the window
        logic hash_step;  // one Horner step on both hashes
        logic idx_clr;
        logic idx_inc;
        logic sel_cmp;    // byte compare addressing
        logic emit_hash;  // load a pattern hash result
        logic emit_pos;   // load a compared position result
        logic finish;     // item done; end-of-text cleanup
    } rhps_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic hit;        // complete window and hashes equal
        logic step_end;   // index at last pattern byte
        logic mismatch;   // compared bytes differ
        logic started;    // pattern hash already reported for this text
    } rhps_sts_t;

    // Digit of a byte read as signed: s mod 3 for s > 0, else (s + 127) rem 3
    function automatic logic signed [2:0] byte_digit(input logic [7:0] b);
        logic [7:0] t;
        logic [6:0] v;
        logic [3:0] a;
        logic [2:0] c;
        logic [2:0] r;
        t = b + 8'd127;
        v = (!b[7] && (b != 8'h00)) ? b[6:0] : t[6:0];
        // mod 3 by summing base-4 digits (4 = 1 mod 3)
        a = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[6]);
        c = 3'(a[1:0]) + 3'(a[3:2]);
        r = (c >= 3'd3) ? c - 3'd3 : c;
        // -128 gives a remainder of -1
        return (b == 8'h80) ? -3'sd1 : $signed(r);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rhps_ctrl.sv */
// Controller state machine for the rolling hash search: sequences hash, report and compare.
`timescale 1ns / 1ps
`default_nettype none

module rhps_ctrl
    import rhps_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire rhps_sts_t sts,
    output rhps_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_HASH      = 5'b00010,
        S_DECIDE    = 5'b00100,
        S_EMIT_HASH = 5'b01000,
        S_CMP       = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept  = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                cmd.idx_inc   = 1'b1;
                if (sts.step_end)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.idx_clr = 1'b1;
                if (!sts.started)
                begin
                    state_next = S_EMIT_HASH;
                end
                else if (sts.hit)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EMIT_HASH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_hash = 1'b1;
                    if (sts.hit)
                    begin
                        state_next = S_CMP;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_CMP:
            begin
                cmd.sel_cmp = 1'b1;
                if (sts.out_free)
                begin
                    cmd.emit_pos = 1'b1;
                    if (sts.mismatch || sts.step_end)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/rhps_dp.sv */
// Datapath for the rolling hash search: config, window, Horner hash unit, output register.
`timescale 1ns / 1ps
`default_nettype none

module rhps_dp
    import rhps_pkg::*;
#(
    parameter int MAX_PATTERN_LENGTH = MAX_PATTERN_LENGTH_DEF,
    parameter int POSITION_BITS      = POSITION_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]           cfg_data,
    input  wire logic [7:0]                 text_byte,
    input  wire logic                       end_of_text,
    input  wire rhps_cmd_t                  cmd,
    output rhps_sts_t                       sts,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            kind,
    output logic signed [HASH_W-1:0]        hash_value,
    output logic [POSITION_BITS-1:0]        position,
    output logic                            last_of_run
);

    localparam int IDX_W = (MAX_PATTERN_LENGTH > 1) ? $clog2(MAX_PATTERN_LENGTH) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN_LENGTH + 1);

    // Configuration registers
    logic [PLEN_W-1:0] plen_reg;
    logic [CFG_W-1:0]  pat_lo_reg;
    logic [CFG_W-1:0]  pat_hi_reg;

    // Search state
    logic [7:0]               win_reg [MAX_PATTERN_LENGTH];
    logic signed [HASH_W-1:0] win_h_reg;
    logic signed [HASH_W-1:0] pat_h_reg;
    logic [POSITION_BITS-1:0] seen_reg;
    logic                     started_reg;
    logic                     end_reg;
    logic [IDX_W-1:0]         idx_reg;

    // Output register
    logic                     out_valid_reg;
    logic                     kind_reg;
    logic signed [HASH_W-1:0] hash_reg;
    logic [POSITION_BITS-1:0] pos_reg;
    logic                     last_reg;

    logic [LEN_W-1:0]         len;
    logic [IDX_W-1:0]         len_m1;
    logic [IDX_W-1:0]         rev_idx;
    logic [IDX_W-1:0]         win_addr;
    logic [IDX_W-1:0]         pat_addr;
    logic [2*CFG_W-1:0]       pat_vec;
    logic [7:0]               win_byte;
    logic [7:0]               pat_byte;
    logic signed [HASH_W-1:0] win_h_next;
    logic signed [HASH_W-1:0] pat_h_next;
    logic [POSITION_BITS-1:0] cmp_pos;
    logic                     hit;
    logic                     step_end;
    logic                     mismatch;
    logic                     out_free;

    // Effective pattern length, clamped to 1..MAX_PATTERN_LENGTH
    always_comb
    begin
        if (plen_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (plen_reg > PLEN_W'(MAX_PATTERN_LENGTH))
        begin
            len = LEN_W'(MAX_PATTERN_LENGTH);
        end
        else
        begin
            len = LEN_W'(plen_reg);
        end
    end

    assign len_m1  = IDX_W'(len - LEN_W'(1));
    assign rev_idx = len_m1 - idx_reg;

    // Hashing walks window newest-first and pattern highest-first; compare walks the reverse
    assign win_addr = cmd.sel_cmp ? rev_idx : idx_reg;
    assign pat_addr = cmd.sel_cmp ? idx_reg : rev_idx;
    assign pat_vec  = {pat_hi_reg, pat_lo_reg};
    assign win_byte = win_reg[win_addr];
    assign pat_byte = pat_vec[8*4'(pat_addr) +: 8];

    // Horner step: h = 3h + digit
    assign win_h_next = (win_h_reg <<< 1) + win_h_reg + HASH_W'(byte_digit(win_byte));
    assign pat_h_next = (pat_h_reg <<< 1) + pat_h_reg + HASH_W'(byte_digit(pat_byte));

    assign hit      = (seen_reg >= POSITION_BITS'(len)) && (win_h_reg == pat_h_reg);
    assign step_end = (idx_reg == len_m1);
    assign mismatch = (win_byte != pat_byte);
    assign out_free = !out_valid_reg || !out_stall;
    // Window start plus index; never exceeds the saturated count
    assign cmp_pos  = seen_reg - POSITION_BITS'(len_m1) + POSITION_BITS'(idx_reg);

    assign sts.out_free = out_free;
    assign sts.hit      = hit;
    assign sts.step_end = step_end;
    assign sts.mismatch = mismatch;
    assign sts.started  = started_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg   <= PLEN_W'(1);
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_PATTERN_LENGTH: plen_reg   <= cfg_data[PLEN_W-1:0];
                CFG_PATTERN_LOW:    pat_lo_reg <= cfg_data;
                CFG_PATTERN_HIGH:   pat_hi_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Text window: entry 0 newest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PATTERN_LENGTH; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (cmd.accept)
        begin
            win_reg[0] <= text_byte;
            for (int k = 1; k < MAX_PATTERN_LENGTH; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
        end
        else if (cmd.finish && end_reg)
        begin
            for (int k = 0; k < MAX_PATTERN_LENGTH; k++)
            begin
                win_reg[k] <= '0;
            end
        end
    end

    // Hashes, byte count, text flags, index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_h_reg   <= '0;
            pat_h_reg   <= '0;
            seen_reg    <= '0;
            started_reg <= 1'b0;
            end_reg     <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                win_h_reg <= '0;
                pat_h_reg <= '0;
                end_reg   <= end_of_text;
                if (seen_reg != '1)
                begin
                    seen_reg <= seen_reg + POSITION_BITS'(1);
                end
            end
            else if (cmd.hash_step)
            begin
                win_h_reg <= win_h_next;
                pat_h_reg <= pat_h_next;
            end
            else if (cmd.finish && end_reg)
            begin
                win_h_reg <= '0;
                seen_reg  <= '0;
            end

            if (cmd.finish && end_reg)
            begin
                started_reg <= 1'b0;
            end
            else if (cmd.emit_hash)
            begin
                started_reg <= 1'b1;
            end

            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_hash || cmd.emit_pos)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_hash)
        begin
            kind_reg <= KIND_HASH;
            hash_reg <= pat_h_reg;
            pos_reg  <= '0;
            last_reg <= !hit;
        end
        else if (cmd.emit_pos)
        begin
            kind_reg <= KIND_POSITION;
            hash_reg <= '0;
            pos_reg  <= cmp_pos;
            last_reg <= mismatch || step_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign hash_value  = hash_reg;
    assign position    = pos_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

/* hw/rtl/rolling_hash_pattern_search.sv */
// Top level of the rolling hash (Rabin-Karp) pattern search block.
`timescale 1ns / 1ps
`default_nettype none

// Searches a byte stream for a configured pattern of L = 1..MAX_PATTERN_LENGTH bytes.
// The first byte of each text first yields the pattern hash (kind 0); every complete
// window whose base-3 hash matches is compared byte by byte, reporting each compared
// 1-based position (kind 1) up to and including the first mismatch; last_of_run marks
// the final result of a request. in_stall stays high until a request is done, also
// while the output stalls; both hashes are rebuilt one digit per cycle, each by its own
// Horner multiply-by-3-and-add step. end_of_text returns the search state to reset for
// the next text. The user writes configuration only while the block is idle (unchecked).

module rolling_hash_pattern_search
    import rhps_pkg::*;
#(
    parameter int MAX_PATTERN_LENGTH = MAX_PATTERN_LENGTH_DEF,
    parameter int POSITION_BITS      = POSITION_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            text_byte,
    input  wire logic                  end_of_text,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       kind,
    output logic signed [HASH_W-1:0]   hash_value,
    output logic [POSITION_BITS-1:0]   position,
    output logic                       last_of_run
);

    rhps_cmd_t cmd;
    rhps_sts_t sts;

    // Controller
    rhps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    rhps_dp #(
        .MAX_PATTERN_LENGTH (MAX_PATTERN_LENGTH),
        .POSITION_BITS      (POSITION_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .text_byte    (text_byte),
        .end_of_text  (end_of_text),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .hash_value   (hash_value),
        .position     (position),
        .last_of_run  (last_of_run)
    );

`ifndef SYNTHESIS
    // An accepted request always starts hashing on the next cycle
    a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> cmd.hash_step)
        else $error("hash did not start after accepted request");

    // Results are loaded only when the output register is free
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_hash || cmd.emit_pos) |-> (!out_valid || !out_stall))
        else $error("result loaded over a pending result");

    // Never two results in one cycle
    a_emit_one: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_hash && cmd.emit_pos))
        else $error("two results loaded at once");

    // No new request taken while results of the current one are being produced
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_hash || cmd.emit_pos || cmd.hash_step) |-> in_stall)
        else $error("input open during item processing");
`endif

endmodule

`default_nettype wire
